// ----- design/lcst_pkg.sv -----
// ----------------------------------------------------------------------------
// lcst_pkg: shared definitions of the least-connections server table
// Field widths, operation and status codes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lcst_pkg;

  localparam int unsigned LCST_SLOTS = 16;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned ENTRY_W = KEY_W + 2 * CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_SELECT = 3'd0,
    FN_INSERT = 3'd1,
    FN_DELETE = 3'd2,
    FN_INCR   = 3'd3,
    FN_DECR   = 3'd4
  } lcst_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_ABSENT = 3'd1,
    STAT_DUP    = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_NONE   = 3'd4
  } lcst_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } lcst_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the request and restart the scan
    logic rd;      // read the slot at the scan index
    logic commit;  // apply the operation and load the result register
  } lcst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan index names the last slot
    logic out_free;   // the result register can take a new item
  } lcst_stat_t;

endpackage

// ----- design/lcst_if.sv -----
// ----------------------------------------------------------------------------
// lcst_if: request and response channels of the server table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lcst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [63:0] server_key;
  logic [15:0]        amount;
  logic [31:0]        start_count;
  logic [31:0]        limit_count;

  modport source (output valid, func, server_key, amount, start_count, limit_count,
                  input ready);
  modport sink   (input valid, func, server_key, amount, start_count, limit_count,
                  output ready);
endinterface

interface lcst_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [63:0] chosen_key;
  logic [31:0]        chosen_count;
  logic [4:0]         entry_total;

  modport source (output valid, status, chosen_key, chosen_count, entry_total,
                  input ready);
  modport sink   (input valid, status, chosen_key, chosen_count, entry_total,
                  output ready);
endinterface

// ----- design/lcst_ram.sv -----
// ----------------------------------------------------------------------------
// lcst_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/lcst_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcst_ctrl: sequencer of the server table
// Takes a request, sweeps the slot RAM once, then commits the operation.
// ----------------------------------------------------------------------------
module lcst_ctrl
  import lcst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lcst_stat_t stat_i,
  output lcst_cmd_t  cmd_o
);

  lcst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // The last slot read returns here and is evaluated.
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lcst_dp.sv -----
// ----------------------------------------------------------------------------
// lcst_dp: datapath of the server table
// Slot RAM, valid bits, scan trackers (key match, first free slot, best
// eligible server), write-back and the result register.
// ----------------------------------------------------------------------------
module lcst_dp
  import lcst_pkg::*;
#(
  parameter int unsigned SLOTS = LCST_SLOTS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcst_cmd_t                cmd_i,
  output lcst_stat_t               stat_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [KEY_W-1:0]  server_key_i,
  input  logic [AMT_W-1:0]         amount_i,
  input  logic [CNT_W-1:0]         start_count_i,
  input  logic [CNT_W-1:0]         limit_count_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [KEY_W-1:0]  chosen_key_o,
  output logic [CNT_W-1:0]         chosen_count_o,
  output logic [TOTAL_W-1:0]       entry_total_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned TW = $clog2(SLOTS + 1);

  // Latched request.
  logic [FUNC_W-1:0]       func_q;
  logic signed [KEY_W-1:0] key_q;
  logic [AMT_W-1:0]        amt_q;
  logic [CNT_W-1:0]        start_q;
  logic [CNT_W-1:0]        limit_q;

  // Scan.
  logic [AW-1:0]    idx_q;
  logic             eval_v_q;
  logic [AW-1:0]    eval_idx_q;
  logic [SLOTS-1:0] valid_q;
  logic [TW-1:0]    total_q;

  // Trackers.
  logic                    hit_q;
  logic [AW-1:0]           hit_idx_q;
  logic [CNT_W-1:0]        hit_cnt_q;
  logic [CNT_W-1:0]        hit_lim_q;
  logic                    free_q;
  logic [AW-1:0]           free_idx_q;
  logic                    best_q;
  logic signed [KEY_W-1:0] best_key_q;
  logic [CNT_W-1:0]        best_cnt_q;

  // RAM.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic signed [KEY_W-1:0] r_key;
  logic [CNT_W-1:0]        r_cnt;
  logic [CNT_W-1:0]        r_lim;
  logic                    r_valid;
  logic                    r_better;

  // Result register.
  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic signed [KEY_W-1:0] ckey_q;
  logic [CNT_W-1:0]        ccnt_q;
  logic [TOTAL_W-1:0]      etotal_q;

  // Commit logic.
  lcst_status_e            status_d;
  logic signed [KEY_W-1:0] ckey_d;
  logic [CNT_W-1:0]        ccnt_d;
  logic [TW-1:0]           total_d;
  logic                    set_valid;
  logic                    clr_valid;
  logic [CNT_W:0]          inc_sum;
  logic [CNT_W-1:0]        amt_ext;
  logic [CNT_W-1:0]        new_cnt;

  lcst_ram #(
    .Width (ENTRY_W),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign stat_o.scan_last = (idx_q == AW'(SLOTS - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign r_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
  assign r_cnt   = ram_rdata[2*CNT_W-1 -: CNT_W];
  assign r_lim   = ram_rdata[CNT_W-1:0];
  assign r_valid = valid_q[eval_idx_q];
  // Lower count wins; equal counts go to the smaller signed key.
  assign r_better = !best_q || (r_cnt < best_cnt_q) ||
                    ((r_cnt == best_cnt_q) && (r_key < best_key_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      key_q   <= server_key_i;
      amt_q   <= amount_i;
      start_q <= start_count_i;
      limit_q <= limit_count_i;
    end
    eval_idx_q <= idx_q;
    if (eval_v_q) begin
      if (r_valid && (r_key == key_q) && !hit_q) begin
        hit_idx_q <= eval_idx_q;
        hit_cnt_q <= r_cnt;
        hit_lim_q <= r_lim;
      end
      if (!r_valid && !free_q) begin
        free_idx_q <= eval_idx_q;
      end
      if (r_valid && (r_cnt < r_lim) && r_better) begin
        best_key_q <= r_key;
        best_cnt_q <= r_cnt;
      end
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      ckey_q   <= ckey_d;
      ccnt_q   <= ccnt_d;
      etotal_q <= TOTAL_W'(total_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      eval_v_q    <= 1'b0;
      valid_q     <= '0;
      total_q     <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      eval_v_q <= cmd_i.rd;
      if (cmd_i.load) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        best_q <= 1'b0;
      end else begin
        if (cmd_i.rd) begin
          idx_q <= idx_q + AW'(1);
        end
        if (eval_v_q) begin
          if (r_valid && (r_key == key_q)) begin
            hit_q <= 1'b1;
          end
          if (!r_valid) begin
            free_q <= 1'b1;
          end
          if (r_valid && (r_cnt < r_lim)) begin
            best_q <= 1'b1;
          end
        end
      end
      if (cmd_i.commit) begin
        total_q <= total_d;
        if (set_valid) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (clr_valid) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign inc_sum = (CNT_W + 1)'(hit_cnt_q) + (CNT_W + 1)'(amt_q);
  assign amt_ext = CNT_W'(amt_q);

  always_comb begin
    status_d  = STAT_OK;
    ckey_d    = '0;
    ccnt_d    = '0;
    total_d   = total_q;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    new_cnt   = hit_cnt_q;
    ram_wdata = {key_q, start_q, limit_q};
    case (func_q)
      FN_SELECT: begin
        if (best_q) begin
          ckey_d = best_key_q;
          ccnt_d = best_cnt_q;
        end else begin
          status_d = STAT_NONE;
        end
      end
      FN_INSERT: begin
        if (hit_q) begin
          status_d = STAT_DUP;
        end else if (!free_q) begin
          status_d = STAT_FULL;
        end else begin
          ram_we    = cmd_i.commit;
          ram_waddr = free_idx_q;
          set_valid = 1'b1;
          total_d   = total_q + TW'(1);
        end
      end
      FN_DELETE: begin
        if (hit_q) begin
          clr_valid = 1'b1;
          total_d   = total_q - TW'(1);
        end else begin
          status_d = STAT_ABSENT;
        end
      end
      FN_INCR: begin
        if (hit_q) begin
          // Saturate at the all-ones count.
          new_cnt   = inc_sum[CNT_W] ? '1 : inc_sum[CNT_W-1:0];
          ram_we    = cmd_i.commit;
          ram_wdata = {key_q, new_cnt, hit_lim_q};
        end else begin
          status_d = STAT_ABSENT;
        end
      end
      FN_DECR: begin
        if (hit_q) begin
          new_cnt   = (amt_ext > hit_cnt_q) ? '0 : hit_cnt_q - amt_ext;
          ram_we    = cmd_i.commit;
          ram_wdata = {key_q, new_cnt, hit_lim_q};
        end else begin
          status_d = STAT_ABSENT;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign chosen_key_o   = ckey_q;
  assign chosen_count_o = ccnt_q;
  assign entry_total_o  = etotal_q;

endmodule

// ----- design/least_connections_server_table.sv -----
// ----------------------------------------------------------------------------
// least_connections_server_table: least-connections server table
// Holds up to SLOTS servers and answers insert, delete, count and select
// requests, one response item for each request item.
// ----------------------------------------------------------------------------
// Usage:
//   Request items enter on req_i and response items leave on rsp_o, both
//   valid/ready channels. Each request sweeps the slot RAM once, one slot
//   per cycle through its single read port, then commits its update and
//   loads the response register.
//   A request is taken only while the controller is idle, so the next
//   request waits until the current one has swept the slots and committed.
//   The next request is taken while a response still waits on rsp_o; that
//   request then holds before its commit until the waiting response leaves.
//   Reset clears all valid bits and the entry count, so the table starts
//   empty with no clearing pass; the slot RAM itself is not cleared.
//   A stalled receiver simply holds the response steady on rsp_o.
// ----------------------------------------------------------------------------
module least_connections_server_table
  import lcst_pkg::*;
#(
  parameter int unsigned SLOTS = LCST_SLOTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcst_req_if.sink  req_i,
  lcst_rsp_if.source rsp_o
);

  lcst_cmd_t  cmd;
  lcst_stat_t stat;

  lcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (req_i.func),
    .server_key_i   (req_i.server_key),
    .amount_i       (req_i.amount),
    .start_count_i  (req_i.start_count),
    .limit_count_i  (req_i.limit_count),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .chosen_key_o   (rsp_o.chosen_key),
    .chosen_count_o (rsp_o.chosen_count),
    .entry_total_o  (rsp_o.entry_total)
  );

endmodule

// ----- design/lcst_checker.sv -----
// ----------------------------------------------------------------------------
// lcst_checker: port-level checks of the server table
// Tracks items in flight and checks busy behavior and response payloads.
// ----------------------------------------------------------------------------
module lcst_checker
  import lcst_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [STAT_W-1:0]       status_i,
  input logic signed [KEY_W-1:0] chosen_key_i,
  input logic [CNT_W-1:0]        chosen_count_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items taken whose responses have not left yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // At most one item in work and one response waiting.
  a_no_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q != 2'd2)
    else $error("request taken while two items are outstanding");

  // A response never appears without an outstanding item.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("response without a request");

  // The table is busy right after it takes a request.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request channel ready right after a request");

  // Only a successful select names a server; everything else reports zero.
  a_zero_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != STAT_OK) |-> (chosen_key_i == '0 && chosen_count_i == '0))
    else $error("chosen server reported on a failed request");

endmodule

bind least_connections_server_table lcst_checker u_lcst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .chosen_key_i   (rsp_o.chosen_key),
  .chosen_count_i (rsp_o.chosen_count)
);

// ----- sim/lcst_table_checker.sv -----
// ----------------------------------------------------------------------------
// lcst_table_checker: response checker of the least-connections server table
// Watches both channels, keeps its own copy of the server table, works out
// the response item for every accepted request item and compares each
// accepted response item with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module lcst_table_checker
  import lcst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lcst_req_if         req_i,
  lcst_rsp_if         rsp_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [KEY_W-1:0]  key;
    logic [CNT_W-1:0]         count;
    logic [TOTAL_W-1:0]       total;
  } answer_t;

  logic                    held       [LCST_SLOTS];
  logic signed [KEY_W-1:0] held_key   [LCST_SLOTS];
  logic [CNT_W-1:0]        held_count [LCST_SLOTS];
  logic [CNT_W-1:0]        held_limit [LCST_SLOTS];

  answer_t answers[$];

  initial begin
    mismatch_o = 0;
    pending_o  = 0;
    foreach (held[i]) begin
      held[i]       = 1'b0;
      held_key[i]   = '0;
      held_count[i] = '0;
      held_limit[i] = '0;
    end
  end

  // Applies one request to the table copy and returns the response it gives.
  function automatic answer_t apply_request(logic [FUNC_W-1:0] func,
                                            logic signed [KEY_W-1:0] key,
                                            logic [AMT_W-1:0] amount,
                                            logic [CNT_W-1:0] start_cnt,
                                            logic [CNT_W-1:0] limit_cnt);
    answer_t     ans;
    int          hit;
    int          best;
    int          free_slot;
    logic [CNT_W:0] sum;
    ans        = '0;
    ans.status = STAT_OK;
    hit        = -1;
    best       = -1;
    free_slot  = -1;
    for (int s = 0; s < LCST_SLOTS; s++) begin
      if (hit < 0 && held[s] && held_key[s] == key) hit = s;
      if (free_slot < 0 && !held[s]) free_slot = s;
    end
    case (func)
      FN_SELECT: begin
        // Lowest count below its limit wins; equal counts go to the lower key.
        for (int s = 0; s < LCST_SLOTS; s++) begin
          if (held[s] && held_count[s] < held_limit[s]) begin
            if (best < 0 || held_count[s] < held_count[best] ||
                (held_count[s] == held_count[best] && held_key[s] < held_key[best]))
              best = s;
          end
        end
        if (best < 0) begin
          ans.status = STAT_NONE;
        end else begin
          ans.key   = held_key[best];
          ans.count = held_count[best];
        end
      end
      FN_INSERT: begin
        if (hit >= 0) begin
          ans.status = STAT_DUP;
        end else if (free_slot < 0) begin
          ans.status = STAT_FULL;
        end else begin
          held[free_slot]       = 1'b1;
          held_key[free_slot]   = key;
          held_count[free_slot] = start_cnt;
          held_limit[free_slot] = limit_cnt;
        end
      end
      FN_DELETE: begin
        if (hit < 0) ans.status = STAT_ABSENT;
        else held[hit] = 1'b0;
      end
      FN_INCR: begin
        if (hit < 0) begin
          ans.status = STAT_ABSENT;
        end else begin
          sum = {1'b0, held_count[hit]} + amount;
          held_count[hit] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
        end
      end
      FN_DECR: begin
        if (hit < 0) ans.status = STAT_ABSENT;
        else if (held_count[hit] < amount) held_count[hit] = '0;
        else held_count[hit] = held_count[hit] - amount;
      end
      default: ;
    endcase
    for (int s = 0; s < LCST_SLOTS; s++) begin
      if (held[s]) ans.total = ans.total + 1'b1;
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (answers.size() == 0) begin
          $error("response item with no request outstanding");
          mismatch_o++;
        end else begin
          want = answers.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            mismatch_o++;
          end
          if (rsp_i.chosen_key !== want.key) begin
            $error("chosen_key: expected %0d, got %0d", want.key, rsp_i.chosen_key);
            mismatch_o++;
          end
          if (rsp_i.chosen_count !== want.count) begin
            $error("chosen_count: expected %0d, got %0d", want.count, rsp_i.chosen_count);
            mismatch_o++;
          end
          if (rsp_i.entry_total !== want.total) begin
            $error("entry_total: expected %0d, got %0d", want.total, rsp_i.entry_total);
            mismatch_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        answers.push_back(apply_request(req_i.func, req_i.server_key, req_i.amount,
                                        req_i.start_count, req_i.limit_count));
      end
      pending_o = answers.size();
    end
  end

endmodule

// ----- sim/least_connections_server_table_tb.sv -----
// ----------------------------------------------------------------------------
// least_connections_server_table_tb: testbench of the server table
// Drives directed and random request items through phases of sender idling
// and receiver stalling; the checker beside the block predicts and compares
// every response item, and this module gives the verdict.
// ----------------------------------------------------------------------------
module least_connections_server_table_tb;
  import lcst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam int POOL_SIZE      = 24;
  localparam int ITEMS_PER_PHASE = 256;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int TAIL_CYCLES    = 2 * (LCST_SLOTS + 3);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned mismatches;
  int unsigned outstanding;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          cycles    = 0;

  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  lcst_req_if req_ch ();
  lcst_rsp_if rsp_ch ();

  least_connections_server_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  lcst_table_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_i      (rsp_ch),
    .mismatch_o (mismatches),
    .pending_o  (outstanding)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.func        = FN_SELECT;
    req_ch.server_key  = '0;
    req_ch.amount      = '0;
    req_ch.start_count = '0;
    req_ch.limit_count = '0;
    rsp_ch.ready       = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_request(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                               logic [AMT_W-1:0] amount, logic [CNT_W-1:0] start_cnt,
                               logic [CNT_W-1:0] limit_cnt);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= func;
    req_ch.server_key  <= key;
    req_ch.amount      <= amount;
    req_ch.start_count <= start_cnt;
    req_ch.limit_count <= limit_cnt;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every outstanding response item is back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic refill_key_pool();
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '1;
    key_pool[3] = '0;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if ($urandom_range(1)) key_pool[i] = {$urandom, $urandom};
      else key_pool[i] = KEY_W'(i - POOL_SIZE / 2);
    end
  endtask

  function automatic logic [CNT_W-1:0] random_count(int span);
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(span);
    if (roll < 80) return $urandom;
    if (roll < 90) return '1 - $urandom_range(20);
    return '1;
  endfunction

  task automatic send_random_item();
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic [AMT_W-1:0]        amount;
    int                      roll;
    roll = $urandom_range(99);
    if (roll < 20)      func = FN_SELECT;
    else if (roll < 45) func = FN_INSERT;
    else if (roll < 57) func = FN_DELETE;
    else if (roll < 76) func = FN_INCR;
    else if (roll < 95) func = FN_DECR;
    else                func = FUNC_W'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST));
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else key = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 50)      amount = AMT_W'($urandom_range(3));
    else if (roll < 90) amount = AMT_W'($urandom);
    else                amount = '1;
    offer_request(func, key, amount, random_count(6), random_count(10));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, missing keys, extremes, saturation, spare codes.
    offer_request(FN_SELECT, '0, '0, '0, '0);
    offer_request(FN_DELETE, KEY_MIN, '0, '0, '0);
    offer_request(FN_INCR, KEY_MAX, '1, '0, '0);
    offer_request(FN_DECR, '1, '1, '0, '0);
    offer_request(FN_INSERT, KEY_MIN, '0, '0, '1);
    offer_request(FN_INSERT, KEY_MAX, '0, '0, 32'd5);
    offer_request(FN_INSERT, KEY_MIN, '0, 32'd3, 32'd9);
    offer_request(FN_SELECT, '0, '0, '0, '0);
    offer_request(FN_INCR, KEY_MIN, '1, '0, '0);
    offer_request(FN_SELECT, '0, '0, '0, '0);
    offer_request(FN_INSERT, '1, '0, '1 - 1'b1, '1);
    offer_request(FN_INCR, '1, '1, '0, '0);
    offer_request(FN_DECR, KEY_MAX, '1, '0, '0);
    offer_request(FN_INSERT, '0, '0, 32'd7, 32'd7);
    offer_request(FN_UNUSED_FIRST, KEY_MAX, '1, '1, '1);
    offer_request(FN_UNUSED_LAST, '1, '1, '1, '1);
    // Fill the table to the last slot, then one insert too many.
    for (int i = 0; i <= LCST_SLOTS - 4; i++) begin
      offer_request(FN_INSERT, KEY_W'(100 + i), '0, CNT_W'(i % 3), 32'd9);
    end
    offer_request(FN_SELECT, '0, '0, '0, '0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      refill_key_pool();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == ITEMS_PER_PHASE / 2) wait_drained();
        send_random_item();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
